/* rtl/core/pfcg_pkg.sv */
// Shared constants, codes and types for the pump flow/current guard.
package pfcg_pkg;

  localparam int ADC_BITS      = 10;
  localparam int ADC_MAX       = (1 << ADC_BITS) - 1;
  localparam int SENS_MV_PER_A = 66;
  localparam int SCALE_DIV     = ADC_MAX * SENS_MV_PER_A;

  localparam logic [10:0] REF_DEFAULT     = 11'd1100;
  localparam logic [10:0] REF_LOW         = 11'd900;
  localparam logic [10:0] REF_HIGH        = 11'd1200;
  localparam logic [15:0] TIMEOUT_DEFAULT = 16'd2000;
  localparam logic [15:0] INRUSH_DEFAULT  = 16'd5000;

  localparam logic [20:0] VCC_MAX  = 21'h1FFFFF;
  localparam logic [14:0] MA15_MAX = 15'h7FFF;
  localparam logic [13:0] MA14_MAX = 14'h3FFF;

  // register indexes on the config port (byte address = 4 * index)
  localparam logic [1:0] REG_REF_MV  = 2'd0;
  localparam logic [1:0] REG_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_INRUSH  = 2'd2;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_NO_FLOW = 2'd1,
    ERR_UNDER   = 2'd2,
    ERR_OVER    = 2'd3
  } err_t;

  // one classified sample waiting for the back end
  typedef struct packed {
    logic [31:0] now_ms;
    logic        flow_active;
    logic [9:0]  center_adc;
    logic [9:0]  range_adc;
    logic [9:0]  current_adc;
    logic [9:0]  bandgap_adc;
  } item_t;

  typedef struct packed {
    logic       start;
    logic [4:0] steps;   // radix-4 steps, two quotient bits each
  } div_ctl_t;

  typedef struct packed {
    logic        relay_on;
    logic        flow_active;
    logic [1:0]  error_code;
    logic [14:0] current_ma;
    logic [14:0] center_ma;
    logic [13:0] range_ma;
    logic [20:0] vcc_mv;
  } result_t;

endpackage

/* rtl/core/pfcg_front.sv */
// Front end: takes samples, tracks flow pin edges and judges flow activity.
module pfcg_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [31:0]          now_ms,
  input  logic                 flow_level,
  input  logic                 flow_read_ok,
  input  logic [9:0]           center_adc,
  input  logic [9:0]           range_adc,
  input  logic [9:0]           current_adc,
  input  logic [9:0]           bandgap_adc,
  input  logic [15:0]          flow_timeout_ms,
  input  logic                 q_full,
  output logic                 q_push,
  output pfcg_pkg::item_t      q_item
);
  import pfcg_pkg::*;

  logic        prev_flow_level;
  logic [31:0] last_pulse_ms;
  logic        accept;
  logic        falling;
  logic [31:0] pulse_ms_next;
  logic [31:0] elapsed;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign falling  = flow_read_ok && prev_flow_level && !flow_level;

  assign pulse_ms_next = falling ? now_ms : last_pulse_ms;
  assign elapsed       = now_ms - pulse_ms_next;   // wraps modulo 2^32

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_flow_level <= 1'b1;
      last_pulse_ms   <= '0;
    end else if (accept) begin
      last_pulse_ms <= pulse_ms_next;
      if (flow_read_ok) begin
        prev_flow_level <= flow_level;
      end
    end
  end

  assign q_push = accept;

  always_comb begin
    q_item.now_ms      = now_ms;
    q_item.flow_active = elapsed < {16'd0, flow_timeout_ms};
    q_item.center_adc  = center_adc;
    q_item.range_adc   = range_adc;
    q_item.current_adc = current_adc;
    q_item.bandgap_adc = bandgap_adc;
  end

endmodule

/* rtl/core/pfcg_fifo.sv */
// Two-entry queue of classified samples between front and back end.
module pfcg_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  pfcg_pkg::item_t      push_item,
  output logic                 full,
  input  logic                 pop,
  output pfcg_pkg::item_t      pop_item,
  output logic                 empty
);
  import pfcg_pkg::*;

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full     = count == 2'd2;
  assign empty    = count == 2'd0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/pfcg_div.sv */
// Radix-4 restoring divider, 32-bit left-aligned dividend, 17-bit divisor.
module pfcg_div (
  input  logic                 clk,
  input  logic                 rst,
  input  pfcg_pkg::div_ctl_t   ctl,
  input  logic [31:0]          dividend,
  input  logic [16:0]          divisor,
  output logic                 done,
  output logic [31:0]          quotient
);
  import pfcg_pkg::*;

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] num;
  logic [16:0] den;
  logic [16:0] rem;
  logic [31:0] quo;

  logic [17:0] r1;
  logic [17:0] r2;
  logic        b1;
  logic        b2;

  always_comb begin
    r1 = {rem, num[31]};
    b1 = r1 >= {1'b0, den};
    if (b1) begin
      r1 = r1 - {1'b0, den};
    end
    r2 = {r1[16:0], num[30]};
    b2 = r2 >= {1'b0, den};
    if (b2) begin
      r2 = r2 - {1'b0, den};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      num <= dividend;
      den <= divisor;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      num <= {num[29:0], 2'b00};
      rem <= r2[16:0];
      quo <= {quo[29:0], b1, b2};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 5'd1);
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= ctl.steps;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

/* rtl/core/pfcg_back.sv */
// Back end: supply and current scaling through the divider, relay decision, result register.
module pfcg_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [10:0]          internal_ref_mv,
  input  logic [15:0]          inrush_ms,
  input  logic                 q_empty,
  input  pfcg_pkg::item_t      q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pfcg_pkg::result_t    result
);
  import pfcg_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_VCC_W = 11'b00000000010,
    ST_SCL_S = 11'b00000000100,
    ST_SCL_W = 11'b00000001000,
    ST_CUR_S = 11'b00000010000,
    ST_CUR_W = 11'b00000100000,
    ST_CEN_S = 11'b00001000000,
    ST_CEN_W = 11'b00010000000,
    ST_RNG_S = 11'b00100000000,
    ST_RNG_W = 11'b01000000000,
    ST_FIN   = 11'b10000000000
  } state_t;

  // radix-4 steps for 22-, 32- and 26-bit dividends
  localparam logic [4:0] STEPS_VCC  = 5'd11;
  localparam logic [4:0] STEPS_SCL  = 5'd16;
  localparam logic [4:0] STEPS_PROD = 5'd13;

  state_t      state;
  state_t      state_next;
  item_t       item;
  logic [20:0] vcc;
  logic [14:0] scale;
  logic [14:0] cur;
  logic [14:0] cen;
  logic [13:0] rng;
  logic        relay_state;
  logic [31:0] relay_on_ms;

  div_ctl_t    div_ctl;
  logic [31:0] div_num;
  logic [16:0] div_den;
  logic        div_done;
  logic [31:0] div_quo;

  logic [21:0] ref_x;
  logic [30:0] vcc_k;
  logic [9:0]  mul_adc;
  logic [24:0] adc_prod;
  logic [9:0]  bg_clamped;

  logic        load;
  logic [31:0] on_elapsed;
  logic        inrush;
  logic [15:0] cur_p_rng;
  logic [15:0] cen_p_rng;
  logic        gt_lo;
  logic        lt_lo;
  logic        lt_hi;
  logic        gt_hi;
  logic        run;
  err_t        err;

  pfcg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign ref_x      = 22'(internal_ref_mv) * 22'(ADC_MAX);
  assign vcc_k      = 31'(vcc) * 31'(1000);
  assign bg_clamped = (q_item.bandgap_adc == 10'd0) ? 10'd1 : q_item.bandgap_adc;
  assign adc_prod   = 25'(mul_adc) * 25'(scale);

  always_comb begin
    case (state)
      ST_CEN_S: mul_adc = item.center_adc;
      ST_RNG_S: mul_adc = item.range_adc;
      default:  mul_adc = item.current_adc;
    endcase
  end

  assign q_pop = (state == ST_IDLE) && !q_empty;

  always_comb begin
    div_ctl.start = 1'b0;
    div_ctl.steps = STEPS_PROD;
    div_num       = {1'b0, adc_prod, 6'd0};
    div_den       = 17'd1000;
    case (state)
      ST_IDLE: begin
        div_ctl.start = !q_empty;
        div_ctl.steps = STEPS_VCC;
        div_num       = {ref_x, 10'd0};
        div_den       = {7'd0, bg_clamped};
      end
      ST_SCL_S: begin
        div_ctl.start = 1'b1;
        div_ctl.steps = STEPS_SCL;
        div_num       = {1'b0, vcc_k};
        div_den       = 17'(SCALE_DIV);
      end
      ST_CUR_S, ST_CEN_S: begin
        div_ctl.start = 1'b1;
      end
      ST_RNG_S: begin
        div_ctl.start = 1'b1;
        div_den       = 17'd2000;
      end
      default: begin
        div_ctl.start = 1'b0;
      end
    endcase
  end

  // relay decision; the window compares are done on sums so nothing goes negative
  assign on_elapsed = item.now_ms - relay_on_ms;
  assign inrush     = relay_state && (on_elapsed < {16'd0, inrush_ms});
  assign cur_p_rng  = {1'b0, cur} + {2'b0, rng};
  assign cen_p_rng  = {1'b0, cen} + {2'b0, rng};
  assign gt_lo      = cur_p_rng > {1'b0, cen};
  assign lt_lo      = cur_p_rng < {1'b0, cen};
  assign lt_hi      = {1'b0, cur} < cen_p_rng;
  assign gt_hi      = {1'b0, cur} > cen_p_rng;
  assign run        = item.flow_active && ((gt_lo && lt_hi) || inrush);

  always_comb begin
    if (!item.flow_active) begin
      err = ERR_NO_FLOW;
    end else if (!inrush && lt_lo) begin
      err = ERR_UNDER;
    end else if (!inrush && gt_hi) begin
      err = ERR_OVER;
    end else begin
      err = ERR_NONE;
    end
  end

  assign load = (state == ST_FIN) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (!q_empty) state_next = ST_VCC_W;
      ST_VCC_W: if (div_done) state_next = ST_SCL_S;
      ST_SCL_S: state_next = ST_SCL_W;
      ST_SCL_W: if (div_done) state_next = ST_CUR_S;
      ST_CUR_S: state_next = ST_CUR_W;
      ST_CUR_W: if (div_done) state_next = ST_CEN_S;
      ST_CEN_S: state_next = ST_CEN_W;
      ST_CEN_W: if (div_done) state_next = ST_RNG_S;
      ST_RNG_S: state_next = ST_RNG_W;
      ST_RNG_W: if (div_done) state_next = ST_FIN;
      ST_FIN:   if (load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // datapath registers; vcc and the mA values saturate at field width
  always_ff @(posedge clk) begin
    if (q_pop) begin
      item <= q_item;
    end
    if (div_done) begin
      case (state)
        ST_VCC_W: vcc   <= (div_quo > 32'(VCC_MAX)) ? VCC_MAX : div_quo[20:0];
        ST_SCL_W: scale <= div_quo[14:0];
        ST_CUR_W: cur   <= (div_quo > 32'(MA15_MAX)) ? MA15_MAX : div_quo[14:0];
        ST_CEN_W: cen   <= (div_quo > 32'(MA15_MAX)) ? MA15_MAX : div_quo[14:0];
        ST_RNG_W: rng   <= (div_quo > 32'(MA14_MAX)) ? MA14_MAX : div_quo[13:0];
        default:  vcc   <= vcc;
      endcase
    end
    if (load) begin
      result.relay_on    <= run;
      result.flow_active <= item.flow_active;
      result.error_code  <= err;
      result.current_ma  <= cur;
      result.center_ma   <= cen;
      result.range_ma    <= rng;
      result.vcc_mv      <= vcc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      relay_state <= 1'b0;
      relay_on_ms <= '0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid   <= 1'b1;
        relay_state <= run;
        if (run && !relay_state) begin
          relay_on_ms <= item.now_ms;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/core/pump_flow_current_guard_core.sv */
// Top level of the pump flow/current guard: config registers, front end, queue, back end.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------------------
//  in      | input     | in_valid / in_stall       | now_ms, flow_level, flow_read_ok, 4 ADCs
//  out     | output    | out_valid / out_stall     | relay_on, flow_active, error_code, mA, mV
//  cfg     | input     | psel/penable/pwrite/pready| paddr, pwdata, prdata (3 registers)
//
//  A sample takes five passes through the shared radix-4 divider in the back end:
//  supply voltage, scale factor, current, center and range.
//  The front end classifies a sample in the cycle it is taken; a two-entry queue
//  lets up to two more samples be taken while the back end is busy.
//  The result register holds a transaction under out_stall while the next one computes.
//  Reset is synchronous; no clearing pass is needed.
module pump_flow_current_guard_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] now_ms,
  input  logic        flow_level,
  input  logic        flow_read_ok,
  input  logic [9:0]  center_adc,
  input  logic [9:0]  range_adc,
  input  logic [9:0]  current_adc,
  input  logic [9:0]  bandgap_adc,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        relay_on,
  output logic        flow_active,
  output logic [1:0]  error_code,
  output logic [14:0] current_ma,
  output logic [14:0] center_ma,
  output logic [13:0] range_ma,
  output logic [20:0] vcc_mv,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pfcg_pkg::*;

  logic [10:0] internal_ref_mv;
  logic [15:0] flow_timeout_ms;
  logic [15:0] inrush_ms;
  logic        cfg_wr;
  logic [10:0] ref_wdata;

  logic        q_push;
  item_t       q_push_item;
  logic        q_full;
  logic        q_pop;
  item_t       q_pop_item;
  logic        q_empty;
  result_t     result;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign ref_wdata = pwdata[10:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      internal_ref_mv <= REF_DEFAULT;
      flow_timeout_ms <= TIMEOUT_DEFAULT;
      inrush_ms       <= INRUSH_DEFAULT;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_REF_MV: begin
          // out-of-range reference falls back to the default
          internal_ref_mv <= (ref_wdata < REF_LOW || ref_wdata > REF_HIGH) ?
                             REF_DEFAULT : ref_wdata;
        end
        REG_TIMEOUT: flow_timeout_ms <= pwdata[15:0];
        REG_INRUSH:  inrush_ms       <= pwdata[15:0];
        default:     inrush_ms       <= inrush_ms;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_REF_MV:  prdata = {21'd0, internal_ref_mv};
      REG_TIMEOUT: prdata = {16'd0, flow_timeout_ms};
      REG_INRUSH:  prdata = {16'd0, inrush_ms};
      default:     prdata = '0;
    endcase
  end

  pfcg_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .now_ms          (now_ms),
    .flow_level      (flow_level),
    .flow_read_ok    (flow_read_ok),
    .center_adc      (center_adc),
    .range_adc       (range_adc),
    .current_adc     (current_adc),
    .bandgap_adc     (bandgap_adc),
    .flow_timeout_ms (flow_timeout_ms),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_item          (q_push_item)
  );

  pfcg_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_pop_item),
    .empty     (q_empty)
  );

  pfcg_back u_back (
    .clk             (clk),
    .rst             (rst),
    .internal_ref_mv (internal_ref_mv),
    .inrush_ms       (inrush_ms),
    .q_empty         (q_empty),
    .q_item          (q_pop_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .result          (result)
  );

  assign relay_on    = result.relay_on;
  assign flow_active = result.flow_active;
  assign error_code  = result.error_code;
  assign current_ma  = result.current_ma;
  assign center_ma   = result.center_ma;
  assign range_ma    = result.range_ma;
  assign vcc_mv      = result.vcc_mv;

endmodule

/* rtl/core/pfcg_checker.sv */
// Port-level checks on the guard's result channel, bound to the top level.
module pfcg_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        relay_on,
  input logic        flow_active,
  input logic [1:0]  error_code,
  input logic [14:0] current_ma,
  input logic [20:0] vcc_mv
);
  import pfcg_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(relay_on) && $stable(error_code) &&
                               $stable(current_ma) && $stable(vcc_mv))
    else $error("stalled result transaction changed");

  a_no_flow_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (flow_active == (error_code != ERR_NO_FLOW)))
    else $error("no-flow code disagrees with flow_active");

  a_relay_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && relay_on |-> flow_active && (error_code == ERR_NONE))
    else $error("relay on with flow missing or an error raised");

endmodule

bind pump_flow_current_guard_core pfcg_checker u_pfcg_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .relay_on    (relay_on),
  .flow_active (flow_active),
  .error_code  (error_code),
  .current_ma  (current_ma),
  .vcc_mv      (vcc_mv)
);
